### design/mbss_pkg.sv
// shared types and constants for the masked byte signature scan
`timescale 1ns / 1ps

package mbss_pkg;

  localparam int ADDR_BITS = 48;
  localparam int PAT_BYTES_MAX = 32;
  localparam int LEN_BITS = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam logic [ADDR_BITS-1:0] ALIGN_MASK = 48'hF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_0 = 3'd0,
    REG_PATTERN_1 = 3'd1,
    REG_PATTERN_2 = 3'd2,
    REG_PATTERN_3 = 3'd3,
    REG_MASK      = 3'd4,
    REG_LENGTH    = 3'd5,
    REG_MODE      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [8*PAT_BYTES_MAX-1:0] pattern;
    logic [PAT_BYTES_MAX-1:0]   must_match_mask;
    logic [LEN_BITS-1:0]        pattern_length;
    logic                       report_mode;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] match_address;
    logic                 found;
    logic                 is_aligned;
    logic                 is_final;
  } result_t;

endpackage

### design/masked_byte_signature_scan_top.sv
// top level of the masked byte signature scan
// an accepted request waits in the input register until the result queue has room
// throughput: one byte per cycle while the queue has room; a byte may yield two results
// the combinational compare between input register and four-entry result queue sets the rate
// reset: rst is synchronous, active high; clears queue, scan state and configuration
// (pattern length resets to one, all other registers to zero)
`timescale 1ns / 1ps

module masked_byte_signature_scan_top #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [55:0]                          s_tdata,  // data_byte, byte_address
  input  logic [0:0]                           s_tuser,  // section_start
  input  logic                                 s_tlast,  // scan_end
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [47:0]                          m_tdata,  // match_address
  output logic [1:0]                           m_tuser,  // found, is_aligned
  output logic                                 m_tlast,  // is_final
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mbss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  mbss_pkg::cfg_t    cfg;
  mbss_pkg::result_t res0;
  mbss_pkg::result_t res1;
  mbss_pkg::result_t out_res;
  logic [1:0]        push_count;
  logic              room;

  mbss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbss_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_byte          (s_tdata[7:0]),
    .in_addr          (s_tdata[55:8]),
    .in_section_start (s_tuser[0]),
    .in_scan_end      (s_tlast),
    .room             (room),
    .push_count       (push_count),
    .res0             (res0),
    .res1             (res1)
  );

  mbss_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .res0       (res0),
    .res1       (res1),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = out_res.match_address;
  assign m_tuser = {out_res.is_aligned, out_res.found};
  assign m_tlast = out_res.is_final;

endmodule

### design/mbss_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module mbss_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mbss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output mbss_pkg::cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern         <= '0;
      cfg.must_match_mask <= '0;
      cfg.pattern_length  <= mbss_pkg::LEN_BITS'(1);
      cfg.report_mode     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mbss_pkg::cfg_reg_e'(cfg_index))
        mbss_pkg::REG_PATTERN_0: cfg.pattern[63:0]    <= cfg_data;
        mbss_pkg::REG_PATTERN_1: cfg.pattern[127:64]  <= cfg_data;
        mbss_pkg::REG_PATTERN_2: cfg.pattern[191:128] <= cfg_data;
        mbss_pkg::REG_PATTERN_3: cfg.pattern[255:192] <= cfg_data;
        mbss_pkg::REG_MASK:      cfg.must_match_mask  <= cfg_data[31:0];
        mbss_pkg::REG_LENGTH:    cfg.pattern_length   <= cfg_data[mbss_pkg::LEN_BITS-1:0];
        mbss_pkg::REG_MODE:      cfg.report_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### design/mbss_core.sv
// input register, byte window, masked compare and match tracking
`timescale 1ns / 1ps

module mbss_core #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mbss_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic [mbss_pkg::ADDR_BITS-1:0]  in_addr,
  input  logic                            in_section_start,
  input  logic                            in_scan_end,
  input  logic                            room,
  output logic [1:0]                      push_count,
  output mbss_pkg::result_t               res0,
  output mbss_pkg::result_t               res1
);

  localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int SHW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = mbss_pkg::LEN_BITS;
  localparam int AW = mbss_pkg::ADDR_BITS;

  // input register
  logic          valid;
  logic [7:0]    cur;
  logic [AW-1:0] addr;
  logic          sec_start;
  logic          scan_end;

  // scan state
  logic [7:0]    win [WIN];
  logic [LW-1:0] fill;
  logic [AW-1:0] first_aligned;
  logic          aligned_seen;
  logic [AW-1:0] first_any;
  logic          any_seen;

  logic                     proc;
  logic [LW-1:0]            len;
  logic [LW-1:0]            fill_eff;
  logic [8*MAX_PATTERN-1:0] r_vec;
  logic [8*MAX_PATTERN-1:0] shifted;
  logic [SHW-1:0]           sh;
  logic                     hit;
  logic [AW-1:0]            start;
  logic                     al;
  logic                     aligned_seen_next;
  logic [AW-1:0]            first_aligned_next;
  logic                     any_seen_next;
  logic [AW-1:0]            first_any_next;
  logic                     rep_aligned;
  mbss_pkg::result_t        aligned_res;
  mbss_pkg::result_t        final_res;

  assign proc = valid && room;
  assign in_ready = !valid || room;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LW'(1);
    end else if (cfg.pattern_length > LW'(MAX_PATTERN)) begin
      len = LW'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
  end

  assign fill_eff = sec_start ? '0 : fill;

  // newest byte at the top, oldest at the bottom; shifting by the unused
  // length lines pattern byte k up with lane k
  always_comb begin
    r_vec = '0;
    r_vec[8*(MAX_PATTERN-1) +: 8] = cur;
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      r_vec[8*i +: 8] = win[MAX_PATTERN-2-i];
    end
  end

  assign sh = SHW'(LW'(MAX_PATTERN) - len);
  assign shifted = r_vec >> {sh, 3'b000};

  always_comb begin
    hit = (LW'(fill_eff + LW'(1)) >= len);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (cfg.must_match_mask[k] && (LW'(k) < len) &&
          (shifted[8*k +: 8] != cfg.pattern[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  assign start = addr - AW'(len - LW'(1));
  assign al = (start & mbss_pkg::ALIGN_MASK) == '0;

  always_comb begin
    aligned_seen_next  = aligned_seen;
    first_aligned_next = first_aligned;
    any_seen_next      = any_seen;
    first_any_next     = first_any;
    if (hit && !any_seen) begin
      any_seen_next  = 1'b1;
      first_any_next = start;
    end
    if (hit && al && !aligned_seen) begin
      aligned_seen_next  = 1'b1;
      first_aligned_next = start;
    end
  end

  assign rep_aligned = cfg.report_mode && hit && al;

  always_comb begin
    aligned_res.match_address = start;
    aligned_res.found         = 1'b1;
    aligned_res.is_aligned    = 1'b1;
    aligned_res.is_final      = 1'b0;

    final_res.match_address = '0;
    final_res.found         = 1'b0;
    final_res.is_aligned    = 1'b0;
    final_res.is_final      = 1'b1;
    if (!cfg.report_mode) begin
      if (aligned_seen_next) begin
        final_res.match_address = first_aligned_next;
        final_res.found         = 1'b1;
        final_res.is_aligned    = 1'b1;
      end else if (any_seen_next) begin
        final_res.match_address = first_any_next;
        final_res.found         = 1'b1;
      end
    end
  end

  always_comb begin
    res0 = rep_aligned ? aligned_res : final_res;
    res1 = final_res;
    push_count = 2'd0;
    if (proc) begin
      push_count = {1'b0, rep_aligned} + {1'b0, scan_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      fill          <= '0;
      aligned_seen  <= 1'b0;
      first_aligned <= '0;
      any_seen      <= 1'b0;
      first_any     <= '0;
    end else begin
      if (in_ready) begin
        valid <= in_valid;
      end
      if (proc) begin
        if (scan_end) begin
          fill          <= '0;
          aligned_seen  <= 1'b0;
          first_aligned <= '0;
          any_seen      <= 1'b0;
          first_any     <= '0;
        end else begin
          fill          <= (fill_eff < LW'(MAX_PATTERN)) ? LW'(fill_eff + LW'(1)) : fill_eff;
          aligned_seen  <= aligned_seen_next;
          first_aligned <= first_aligned_next;
          any_seen      <= any_seen_next;
          first_any     <= first_any_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur       <= in_byte;
      addr      <= in_addr;
      sec_start <= in_section_start;
      scan_end  <= in_scan_end;
    end
    if (proc) begin
      win[0] <= cur;
      for (int i = 1; i < WIN; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

endmodule

### design/mbss_outq.sv
// four-entry result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps

module mbss_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  mbss_pkg::result_t res0,
  input  mbss_pkg::result_t res1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output mbss_pkg::result_t out_res
);

  localparam int DEPTH = 4;

  mbss_pkg::result_t mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two results from one request
  assign room      = (count <= 3'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= res1;
    end
  end

endmodule

### tb/tb.sv
// self-checking testbench for the masked byte signature scan top level
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PIPE_SETTLE = 4;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES = 128;
  localparam logic [mbss_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0]                     data;
    logic [mbss_pkg::ADDR_BITS-1:0] addr;
    logic                           sec;
    logic                           last;
  } mem_byte_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [55:0]                         s_tdata = '0;   // data_byte, byte_address
  logic [0:0]                          s_tuser = '0;   // section_start
  logic                                s_tlast = 1'b0; // scan_end
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [47:0]                         m_tdata;        // match_address
  logic [1:0]                          m_tuser;        // found, is_aligned
  logic                                m_tlast;        // is_final
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [mbss_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [mbss_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  masked_byte_signature_scan_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the configuration registers
  logic [8*mbss_pkg::PAT_BYTES_MAX-1:0] pat_bytes = '0;
  logic [mbss_pkg::PAT_BYTES_MAX-1:0]   pat_care = '0;
  logic [mbss_pkg::LEN_BITS-1:0]        pat_len_reg = 6'd1;
  logic                                 every_aligned = 1'b0;

  // scan state of the predictor
  logic [7:0]                     history [mbss_pkg::PAT_BYTES_MAX-1];
  int                             sec_fill = 0;
  logic [mbss_pkg::ADDR_BITS-1:0] first_aligned = '0;
  logic [mbss_pkg::ADDR_BITS-1:0] first_any = '0;
  bit                             aligned_hit = 1'b0;
  bit                             any_hit = 1'b0;

  mem_byte_t           bytes_to_send [$];
  mbss_pkg::result_t   expected_hits [$];
  int                  mismatches = 0;
  int                  cycles = 0;
  bit                  send_idle = 1'b1;
  bit                  recv_idle = 1'b1;

  function automatic int used_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > mbss_pkg::PAT_BYTES_MAX) return mbss_pkg::PAT_BYTES_MAX;
    return pat_len_reg;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic expect_result(input mbss_pkg::result_t r);
    expected_hits.insert(expected_hits.size(), r);
  endtask

  task automatic send_later(input mem_byte_t b);
    bytes_to_send.insert(bytes_to_send.size(), b);
  endtask

  // advance the scan by one byte and queue the results it causes
  task automatic match_byte(input mem_byte_t b);
    int                             len;
    int                             k;
    bit                             hit;
    bit                             al;
    logic [7:0]                     seen;
    logic [mbss_pkg::ADDR_BITS-1:0] start;
    len = used_len();
    if (b.sec) sec_fill = 0;
    hit = (sec_fill + 1 >= len);
    for (k = 0; k < len && hit; k++) begin
      if (pat_care[k]) begin
        seen = (k == len - 1) ? b.data : history[len - 2 - k];
        if (seen != pat_bytes[8*k +: 8]) hit = 1'b0;
      end
    end
    if (hit) begin
      start = b.addr - (len - 1);
      al = ((start & mbss_pkg::ALIGN_MASK) == '0);
      if (!any_hit) begin
        any_hit = 1'b1;
        first_any = start;
      end
      if (al && !aligned_hit) begin
        aligned_hit = 1'b1;
        first_aligned = start;
      end
      if (every_aligned && al) expect_result({start, 1'b1, 1'b1, 1'b0});
    end
    for (k = mbss_pkg::PAT_BYTES_MAX - 2; k > 0; k--) history[k] = history[k-1];
    history[0] = b.data;
    if (sec_fill < mbss_pkg::PAT_BYTES_MAX) sec_fill++;
    if (b.last) begin
      if (every_aligned) expect_result({48'h0, 1'b0, 1'b0, 1'b1});
      else if (aligned_hit) expect_result({first_aligned, 1'b1, 1'b1, 1'b1});
      else if (any_hit) expect_result({first_any, 1'b1, 1'b0, 1'b1});
      else expect_result({48'h0, 1'b0, 1'b0, 1'b1});
      sec_fill = 0;
      aligned_hit = 1'b0;
      first_aligned = '0;
      any_hit = 1'b0;
      first_any = '0;
    end
  endtask

  // input side: one request per handshake, random gaps between requests while send_idle is set
  mem_byte_t on_bus;
  int        send_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) match_byte(on_bus);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          on_bus = bytes_to_send.pop_front();
          s_tdata <= {on_bus.addr, on_bus.data};
          s_tuser <= on_bus.sec;
          s_tlast <= on_bus.last;
          s_tvalid <= 1'b1;
          send_gap = send_idle ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: compare each result with the oldest expectation
  mbss_pkg::result_t got;
  mbss_pkg::result_t want;
  int                stall = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result addr=%h found=%b aligned=%b final=%b",
                   $time, got.match_address, got.found, got.is_aligned, got.is_final);
          mismatches++;
        end else begin
          want = expected_hits.pop_front();
          if (got.match_address !== want.match_address || got.found !== want.found ||
              got.is_aligned !== want.is_aligned || got.is_final !== want.is_final) begin
            $display("%0t: expected addr=%h found=%b aligned=%b final=%b", $time,
                     want.match_address, want.found, want.is_aligned, want.is_final);
            $display("%0t: actual   addr=%h found=%b aligned=%b final=%b", $time,
                     got.match_address, got.found, got.is_aligned, got.is_final);
            mismatches++;
          end
        end
      end
      if (stall > 0) begin
        stall = stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (recv_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [mbss_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mbss_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mbss_pkg::REG_PATTERN_0: pat_bytes[63:0] = val;
      mbss_pkg::REG_PATTERN_1: pat_bytes[127:64] = val;
      mbss_pkg::REG_PATTERN_2: pat_bytes[191:128] = val;
      mbss_pkg::REG_PATTERN_3: pat_bytes[255:192] = val;
      mbss_pkg::REG_MASK:      pat_care = val[31:0];
      mbss_pkg::REG_LENGTH:    pat_len_reg = val[5:0];
      mbss_pkg::REG_MODE:      every_aligned = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic [mbss_pkg::ADDR_BITS-1:0] a,
                            input logic s, input logic l);
    send_later({d, a, s, l});
  endtask

  task automatic add_byte(input logic [7:0] d, inout logic [mbss_pkg::ADDR_BITS-1:0] a,
                          inout logic s, inout int count);
    send_later({d, a, s, 1'b0});
    a = a + 1;
    s = 1'b0;
    count++;
  endtask

  // one scan: noise, planted patterns (mostly at aligned starts), broken ones
  task automatic queue_scan(input int want_items);
    logic [mbss_pkg::ADDR_BITS-1:0] a;
    logic                           s;
    int                             count;
    int                             len;
    int                             k;
    int                             spoil;
    int                             spoil_at;
    mem_byte_t                      tail;
    len = used_len();
    a = mbss_pkg::ADDR_BITS'({$urandom, $urandom});
    s = 1'b1;
    count = 0;
    while (count < want_items) begin
      case ($urandom_range(0, 11))
        0: begin
          a = mbss_pkg::ADDR_BITS'({$urandom, $urandom});
          s = 1'b1;
        end
        1: a = mbss_pkg::ADDR_BITS'({$urandom, $urandom});
        2, 3, 4: repeat ($urandom_range(1, 6)) add_byte(8'($urandom), a, s, count);
        default: begin
          if ($urandom_range(0, 3) != 0)
            while ((a & mbss_pkg::ALIGN_MASK) != '0) add_byte(8'($urandom), a, s, count);
          spoil = $urandom_range(0, 9);
          spoil_at = $urandom_range(0, len - 1);
          for (k = 0; k < len; k++) begin
            if (spoil == 1 && k == spoil_at) s = 1'b1;
            if (spoil == 0 && k == spoil_at)
              add_byte(~pat_bytes[8*k +: 8], a, s, count);
            else
              add_byte(pat_care[k] ? pat_bytes[8*k +: 8] : 8'($urandom), a, s, count);
          end
        end
      endcase
    end
    tail = bytes_to_send.pop_back();
    tail.last = 1'b1;
    send_later(tail);
  endtask

  task automatic random_setup();
    int                                 r;
    logic [mbss_pkg::CFG_DATA_BITS-1:0] v;
    write_reg(mbss_pkg::REG_PATTERN_0, {$urandom, $urandom});
    write_reg(mbss_pkg::REG_PATTERN_1, {$urandom, $urandom});
    write_reg(mbss_pkg::REG_PATTERN_2, {$urandom, $urandom});
    write_reg(mbss_pkg::REG_PATTERN_3, {$urandom, $urandom});
    v = {$urandom, $urandom};
    r = $urandom_range(0, 5);
    if (r == 0) v[31:0] = '1;
    else if (r == 1) v[31:0] = '0;
    else if (r > 3) v[31:0] = $urandom | $urandom;
    write_reg(mbss_pkg::REG_MASK, v);
    v = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r == 0) v[5:0] = 6'd0;
    else if (r == 1) v[5:0] = 6'($urandom_range(mbss_pkg::PAT_BYTES_MAX + 1, 63));
    else if (r < 5) v[5:0] = 6'(mbss_pkg::PAT_BYTES_MAX);
    else if (r < 9) v[5:0] = 6'($urandom_range(9, mbss_pkg::PAT_BYTES_MAX - 1));
    else v[5:0] = 6'($urandom_range(1, 8));
    write_reg(mbss_pkg::REG_LENGTH, v);
    write_reg(mbss_pkg::REG_MODE, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // everything sent and every result back, then let the pipeline settle
  task automatic wait_idle();
    while (bytes_to_send.size() > 0 || s_tvalid || expected_hits.size() > 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  initial begin
    int p;
    int sent;
    int n;
    foreach (history[i]) history[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: one wildcard byte, so every byte is an unaligned hit
    queue_byte(8'h00, 48'h0000_0000_0001, 1'b1, 1'b0);
    queue_byte(8'hFF, 48'h0000_0000_0002, 1'b0, 1'b0);
    queue_byte(8'h5A, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
    wait_idle();

    // report every aligned match; a pattern cut by a section start is no match,
    // and an aligned match on the last byte gives two results
    write_reg(mbss_pkg::REG_PATTERN_0, 64'h0706_0504_0302_0100);
    write_reg(mbss_pkg::REG_MASK, 64'hF);
    write_reg(mbss_pkg::REG_LENGTH, 64'd4);
    write_reg(mbss_pkg::REG_MODE, 64'd1);
    queue_byte(8'h00, 48'h40, 1'b1, 1'b0);
    queue_byte(8'h01, 48'h41, 1'b0, 1'b0);
    queue_byte(8'h02, 48'h42, 1'b1, 1'b0);
    queue_byte(8'h03, 48'h43, 1'b0, 1'b0);
    queue_byte(8'h00, 48'h20, 1'b0, 1'b0);
    queue_byte(8'h01, 48'h21, 1'b0, 1'b0);
    queue_byte(8'h02, 48'h22, 1'b0, 1'b0);
    queue_byte(8'h03, 48'h23, 1'b0, 1'b1);
    wait_idle();

    // start address wraps below zero, reported as unaligned fallback
    write_reg(mbss_pkg::REG_MODE, 64'd0);
    queue_byte(8'h00, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b0);
    queue_byte(8'h01, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    queue_byte(8'h02, 48'h0000_0000_0000, 1'b0, 1'b0);
    queue_byte(8'h03, 48'h0000_0000_0001, 1'b0, 1'b1);
    wait_idle();

    // zero length acts as one; aligned hit wins over an earlier unaligned one
    write_reg(mbss_pkg::REG_PATTERN_0, 64'hFF);
    write_reg(mbss_pkg::REG_MASK, 64'h1);
    write_reg(mbss_pkg::REG_LENGTH, 64'd0);
    queue_byte(8'hFF, 48'h7, 1'b1, 1'b0);
    queue_byte(8'h00, 48'h10, 1'b0, 1'b0);
    queue_byte(8'hFF, 48'h8000_0000_0000, 1'b0, 1'b0);
    queue_byte(8'h00, 48'h1, 1'b0, 1'b1);
    wait_idle();

    // oversized length acts as the maximum; too few bytes gives not-found
    write_reg(mbss_pkg::REG_PATTERN_1, '1);
    write_reg(mbss_pkg::REG_PATTERN_2, 64'hAAAA_AAAA_AAAA_AAAA);
    write_reg(mbss_pkg::REG_PATTERN_3, 64'h5555_5555_5555_5555);
    write_reg(mbss_pkg::REG_MASK, 64'h0);
    write_reg(mbss_pkg::REG_LENGTH, 64'd63);
    write_reg(REG_UNUSED, '1);
    queue_byte(8'h00, 48'h0, 1'b1, 1'b0);
    queue_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        n = bytes_to_send.size();
        queue_scan($urandom_range(4, 60));
        sent += bytes_to_send.size() - n;
      end
      wait_idle();
    end

    repeat (4 * PIPE_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
